// File: sv/cbsu_pkg.sv
`timescale 1ns / 1ps

package cbsu_pkg;

  // Operation codes.
  localparam logic [2:0] CMD_TSB = 3'd0;
  localparam logic [2:0] CMD_TRB = 3'd1;
  localparam logic [2:0] CMD_BIT = 3'd2;
  localparam logic [2:0] CMD_ASL = 3'd3;
  localparam logic [2:0] CMD_LSR = 3'd4;
  localparam logic [2:0] CMD_ROL = 3'd5;
  localparam logic [2:0] CMD_ROR = 3'd6;

  // Addressing mode codes.
  localparam logic [2:0] MODE_ACC  = 3'd0;
  localparam logic [2:0] MODE_IMM  = 3'd1;
  localparam logic [2:0] MODE_DP   = 3'd2;
  localparam logic [2:0] MODE_DPX  = 3'd3;
  localparam logic [2:0] MODE_ABS  = 3'd4;
  localparam logic [2:0] MODE_ABSX = 3'd5;

  // One instruction as it enters the unit.
  typedef struct packed {
    logic [2:0]  cmd;
    logic [2:0]  addressing_mode;
    logic [23:0] access_address;
    logic [15:0] mem_in;
    logic [15:0] acc_in;
    logic        narrow_mode;
    logic        carry_in;
    logic        neg_in;
    logic        ovf_in;
    logic        dp_low_nonzero;
    logic        page_crossed;
  } item_t;

  // One result as it leaves the unit.
  typedef struct packed {
    logic [15:0] acc_out;
    logic        mem_write;
    logic [23:0] write_address;
    logic [15:0] mem_out;
    logic        neg_out;
    logic        ovf_out;
    logic        zero_out;
    logic        carry_out;
    logic [1:0]  extra_cycles;
  } result_t;

endpackage

// File: sv/cbsu_alu.sv
`timescale 1ns / 1ps

module cbsu_alu (
  input  cbsu_pkg::item_t   item,
  output cbsu_pkg::result_t res
);
  import cbsu_pkg::*;

  logic [15:0] a;
  logic [15:0] m;
  logic [15:0] x;
  logic [15:0] r;
  logic        x_top;
  logic        r_top;
  logic        rot_in;
  logic        mode_cyc;
  logic [1:0]  wide_two;
  logic [1:0]  wide_one;
  logic        on_acc;

  always_comb begin
    // Operands masked to the working width.
    a = item.narrow_mode ? {8'h00, item.acc_in[7:0]} : item.acc_in;
    m = item.narrow_mode ? {8'h00, item.mem_in[7:0]} : item.mem_in;
    on_acc = (item.addressing_mode == MODE_ACC);
    x = on_acc ? a : m;
    x_top = item.narrow_mode ? x[7] : x[15];

    // Shift and rotate datapath for both widths.
    rot_in = 1'b0;
    r = 16'h0000;
    case (item.cmd)
      CMD_ASL, CMD_ROL: begin
        rot_in = (item.cmd == CMD_ROL) & item.carry_in;
        r = item.narrow_mode ? {8'h00, x[6:0], rot_in} : {x[14:0], rot_in};
      end
      CMD_LSR, CMD_ROR: begin
        rot_in = (item.cmd == CMD_ROR) & item.carry_in;
        r = item.narrow_mode ? {8'h00, rot_in, x[7:1]} : {rot_in, x[15:1]};
      end
      default: begin
        r = 16'h0000;
      end
    endcase
    r_top = item.narrow_mode ? r[7] : r[15];

    // Extra cycles from direct page alignment and page crossing.
    if ((item.addressing_mode == MODE_DP) || (item.addressing_mode == MODE_DPX)) begin
      mode_cyc = item.dp_low_nonzero;
    end else if (item.addressing_mode == MODE_ABSX) begin
      mode_cyc = item.page_crossed;
    end else begin
      mode_cyc = 1'b0;
    end
    wide_two = item.narrow_mode ? 2'd0 : 2'd2;
    wide_one = item.narrow_mode ? 2'd0 : 2'd1;

    // Defaults: no operation, flags pass through.
    res.acc_out       = item.acc_in;
    res.mem_write     = 1'b0;
    res.write_address = item.access_address;
    res.mem_out       = 16'h0000;
    res.neg_out       = item.neg_in;
    res.ovf_out       = item.ovf_in;
    res.zero_out      = 1'b0;
    res.carry_out     = item.carry_in;
    res.extra_cycles  = 2'd0;

    case (item.cmd)
      CMD_TSB, CMD_TRB: begin
        res.zero_out  = ((a & m) == 16'h0000);
        res.mem_write = 1'b1;
        res.mem_out   = (item.cmd == CMD_TSB) ? (m | a) : (m & ~a);
        res.extra_cycles = wide_two +
          {1'b0, (item.addressing_mode == MODE_DP) & item.dp_low_nonzero};
      end
      CMD_BIT: begin
        if (item.addressing_mode != MODE_IMM) begin
          res.neg_out = item.narrow_mode ? m[7] : m[15];
          res.ovf_out = item.narrow_mode ? m[6] : m[14];
        end
        res.zero_out     = ((a & m) == 16'h0000);
        res.extra_cycles = wide_one + {1'b0, mode_cyc};
      end
      CMD_ASL, CMD_LSR, CMD_ROL, CMD_ROR: begin
        res.carry_out = ((item.cmd == CMD_ASL) || (item.cmd == CMD_ROL)) ? x_top : x[0];
        res.neg_out   = r_top;
        res.zero_out  = (r == 16'h0000);
        if (on_acc) begin
          res.acc_out = item.narrow_mode ? {item.acc_in[15:8], r[7:0]} : r;
        end else begin
          res.mem_write    = 1'b1;
          res.mem_out      = r;
          res.extra_cycles = wide_two + {1'b0, mode_cyc};
        end
      end
      default: begin
        res.zero_out = 1'b0;
      end
    endcase
  end

endmodule

// File: sv/cpu_bit_shift_unit.sv
`timescale 1ns / 1ps
// Channel  | Ports                         | Transfer when
// ---------+-------------------------------+-----------------------------
// input    | in_valid, in_ready, in_<field>| in_valid && in_ready
// result   | out_valid, out_ready, out_<f> | out_valid && out_ready
//
// One instruction per cycle is accepted while the input register is empty or its item moves on.
// It is held in the input register; its result is then held in the result register and offered there.
// The ALU step between the two registers is a single pass of combinational logic.
// Reset (rst_n low, synchronous) empties both registers.
// A stall on the result side holds the result register; the input register
// still takes an item while the result register has room or is being drained.

module cpu_bit_shift_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_cmd,
  input  logic [2:0]  in_addressing_mode,
  input  logic [23:0] in_access_address,
  input  logic [15:0] in_mem_in,
  input  logic [15:0] in_acc_in,
  input  logic        in_narrow_mode,
  input  logic        in_carry_in,
  input  logic        in_neg_in,
  input  logic        in_ovf_in,
  input  logic        in_dp_low_nonzero,
  input  logic        in_page_crossed,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_acc_out,
  output logic        out_mem_write,
  output logic [23:0] out_write_address,
  output logic [15:0] out_mem_out,
  output logic        out_neg_out,
  output logic        out_ovf_out,
  output logic        out_zero_out,
  output logic        out_carry_out,
  output logic [1:0]  out_extra_cycles
);
  import cbsu_pkg::*;

  logic    s1_valid_r;
  logic    s1_valid_nxt;
  item_t   s1_item_r;
  item_t   in_item;
  logic    s2_valid_r;
  logic    s2_valid_nxt;
  result_t s2_res_r;
  result_t alu_res;
  logic    s1_advance;
  logic    in_xfer;

  // Gather the input ports into one item.
  always_comb begin
    in_item.cmd             = in_cmd;
    in_item.addressing_mode = in_addressing_mode;
    in_item.access_address  = in_access_address;
    in_item.mem_in          = in_mem_in;
    in_item.acc_in          = in_acc_in;
    in_item.narrow_mode     = in_narrow_mode;
    in_item.carry_in        = in_carry_in;
    in_item.neg_in          = in_neg_in;
    in_item.ovf_in          = in_ovf_in;
    in_item.dp_low_nonzero  = in_dp_low_nonzero;
    in_item.page_crossed    = in_page_crossed;
  end

  // Pipeline flow control: each stage moves when the one after it has room.
  assign s1_advance = s1_valid_r && (!s2_valid_r || out_ready);
  assign in_ready   = !s1_valid_r || s1_advance;
  assign in_xfer    = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = in_xfer || (s1_valid_r && !s1_advance);
    s2_valid_nxt = s1_advance || (s2_valid_r && !out_ready);
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  // Payload registers load only on a transfer into their stage.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item_r <= in_item;
    end
    if (s1_advance) begin
      s2_res_r <= alu_res;
    end
  end

  cbsu_alu u_alu (
    .item (s1_item_r),
    .res  (alu_res)
  );

  // Result ports.
  assign out_valid         = s2_valid_r;
  assign out_acc_out       = s2_res_r.acc_out;
  assign out_mem_write     = s2_res_r.mem_write;
  assign out_write_address = s2_res_r.write_address;
  assign out_mem_out       = s2_res_r.mem_out;
  assign out_neg_out       = s2_res_r.neg_out;
  assign out_ovf_out       = s2_res_r.ovf_out;
  assign out_zero_out      = s2_res_r.zero_out;
  assign out_carry_out     = s2_res_r.carry_out;
  assign out_extra_cycles  = s2_res_r.extra_cycles;

endmodule

// File: sv/cbsu_checker.sv
`timescale 1ns / 1ps

module cbsu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_acc_out,
  input logic        out_mem_write,
  input logic [15:0] out_mem_out,
  input logic [1:0]  out_extra_cycles
);

  // The cycle after reset shows no result.
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  // A stalled result holds its data.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_mem_out) && $stable(out_acc_out)
      && $stable(out_extra_cycles))
    else $error("stalled result changed");

  // Write-back data is zero whenever no write-back is requested.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_mem_write |-> out_mem_out == 16'h0000)
    else $error("write data without write request");

  // An accepted item reaches the output if the sink is ready while the item sits in the input register.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) ##1 out_ready |=> out_valid)
    else $error("accepted item did not reach the output");

endmodule

bind cpu_bit_shift_unit cbsu_checker u_cbsu_checker (.*);

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import cbsu_pkg::*;

  // Codes that the package leaves unnamed.
  localparam logic [2:0] CMD_NONE   = 3'd7;
  localparam logic [2:0] MODE_OTHER = 3'd6;
  localparam logic [2:0] MODE_SPARE = 3'd7;

  localparam int RANDOM_ITEMS = 400;
  localparam int QUIET_TAIL   = 60;

  // Works out the outcome of each accepted instruction and checks the
  // results against those outcomes in order of arrival.
  class bit_op_tracker;
    result_t outcomes[$];
    int      mismatches;

    function new();
      mismatches = 0;
    endfunction

    // Direct page modes pay for a misaligned direct page, and absolute
    // indexed X mode pays for a page crossing.
    function int mode_extra(logic [2:0] mode, logic dl, logic pc);
      if (mode == MODE_DP || mode == MODE_DPX) return int'(dl);
      if (mode == MODE_ABSX) return int'(pc);
      return 0;
    endfunction

    function result_t alu_outcome(item_t it);
      result_t     res;
      logic [15:0] w;
      logic [15:0] top;
      logic [15:0] a;
      logic [15:0] m;
      logic [15:0] x;
      logic [15:0] r;
      logic [15:0] acc;
      logic [15:0] mout;
      logic        c;
      logic        n;
      logic        v;
      logic        z;
      logic        wr;
      logic        on_acc;
      int          cyc;

      w    = it.narrow_mode ? 16'h00FF : 16'hFFFF;
      top  = it.narrow_mode ? 16'h0080 : 16'h8000;
      a    = it.acc_in & w;
      m    = it.mem_in & w;
      acc  = it.acc_in;
      mout = 16'h0000;
      c    = it.carry_in;
      n    = it.neg_in;
      v    = it.ovf_in;
      z    = 1'b0;
      wr   = 1'b0;
      cyc  = 0;

      case (it.cmd)
        // Test and set or reset bits: always written back.
        CMD_TSB, CMD_TRB: begin
          z    = ((a & m) == 16'h0000);
          mout = (it.cmd == CMD_TSB) ? (m | a) : (m & ~a & w);
          wr   = 1'b1;
          cyc  = (it.narrow_mode ? 0 : 2) +
                 ((it.addressing_mode == MODE_DP) ? int'(it.dp_low_nonzero) : 0);
        end
        // Bit test: N and V from the operand except in immediate mode.
        CMD_BIT: begin
          if (it.addressing_mode != MODE_IMM) begin
            n = |(m & top);
            v = |(m & (top >> 1));
          end
          z   = ((a & m) == 16'h0000);
          cyc = (it.narrow_mode ? 0 : 1) +
                mode_extra(it.addressing_mode, it.dp_low_nonzero, it.page_crossed);
        end
        // Shifts and rotates, on the accumulator or on memory.
        CMD_ASL, CMD_LSR, CMD_ROL, CMD_ROR: begin
          on_acc = (it.addressing_mode == MODE_ACC);
          x      = on_acc ? a : m;
          if (it.cmd == CMD_ASL || it.cmd == CMD_ROL) begin
            c = |(x & top);
            r = ((x << 1) | {15'd0, it.carry_in & (it.cmd == CMD_ROL)}) & w;
          end else begin
            c = x[0];
            r = (x >> 1) | ((it.cmd == CMD_ROR && it.carry_in) ? top : 16'h0000);
          end
          n = |(r & top);
          z = (r == 16'h0000);
          if (on_acc) begin
            acc = (it.acc_in & ~w) | r;
          end else begin
            wr   = 1'b1;
            mout = r;
            cyc  = (it.narrow_mode ? 0 : 2) +
                   mode_extra(it.addressing_mode, it.dp_low_nonzero, it.page_crossed);
          end
        end
        // The unused command does nothing and clears Z.
        default: begin
        end
      endcase

      res.acc_out       = acc;
      res.mem_write     = wr;
      res.write_address = it.access_address;
      res.mem_out       = mout;
      res.neg_out       = n;
      res.ovf_out       = v;
      res.zero_out      = z;
      res.carry_out     = c;
      res.extra_cycles  = 2'(cyc);
      return res;
    endfunction

    function void note_instruction(item_t it);
      outcomes.push_back(alu_outcome(it));
    endfunction

    function int pending();
      return outcomes.size();
    endfunction

    function void check_field(string name, logic [23:0] want, logic [23:0] got);
      if (got !== want) begin
        $error("%s: expected %h, actual %h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_outcome(result_t got);
      result_t want;
      if (outcomes.size() == 0) begin
        $error("result transfer with no instruction outstanding: acc_out %h", got.acc_out);
        mismatches++;
        return;
      end
      want = outcomes.pop_front();
      check_field("acc_out", 24'(want.acc_out), 24'(got.acc_out));
      check_field("mem_write", 24'(want.mem_write), 24'(got.mem_write));
      check_field("write_address", want.write_address, got.write_address);
      check_field("mem_out", 24'(want.mem_out), 24'(got.mem_out));
      check_field("neg_out", 24'(want.neg_out), 24'(got.neg_out));
      check_field("ovf_out", 24'(want.ovf_out), 24'(got.ovf_out));
      check_field("zero_out", 24'(want.zero_out), 24'(got.zero_out));
      check_field("carry_out", 24'(want.carry_out), 24'(got.carry_out));
      check_field("extra_cycles", 24'(want.extra_cycles), 24'(got.extra_cycles));
    endfunction
  endclass

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          out_ready;
  item_t         stim;
  logic          in_ready;
  logic          out_valid;
  logic [15:0]   out_acc_out;
  logic          out_mem_write;
  logic [23:0]   out_write_address;
  logic [15:0]   out_mem_out;
  logic          out_neg_out;
  logic          out_ovf_out;
  logic          out_zero_out;
  logic          out_carry_out;
  logic [1:0]    out_extra_cycles;
  result_t       seen;
  bit_op_tracker tracker;
  int            gap_pct;
  int            stall_pct;
  bit            quiet;

  cpu_bit_shift_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_cmd            (stim.cmd),
    .in_addressing_mode(stim.addressing_mode),
    .in_access_address (stim.access_address),
    .in_mem_in         (stim.mem_in),
    .in_acc_in         (stim.acc_in),
    .in_narrow_mode    (stim.narrow_mode),
    .in_carry_in       (stim.carry_in),
    .in_neg_in         (stim.neg_in),
    .in_ovf_in         (stim.ovf_in),
    .in_dp_low_nonzero (stim.dp_low_nonzero),
    .in_page_crossed   (stim.page_crossed),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_acc_out       (out_acc_out),
    .out_mem_write     (out_mem_write),
    .out_write_address (out_write_address),
    .out_mem_out       (out_mem_out),
    .out_neg_out       (out_neg_out),
    .out_ovf_out       (out_ovf_out),
    .out_zero_out      (out_zero_out),
    .out_carry_out     (out_carry_out),
    .out_extra_cycles  (out_extra_cycles)
  );

  assign seen = {out_acc_out, out_mem_write, out_write_address, out_mem_out,
                 out_neg_out, out_ovf_out, out_zero_out, out_carry_out,
                 out_extra_cycles};

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watch both channels; every transfer is taken at the clock edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) tracker.note_instruction(stim);
      if (out_valid && out_ready) tracker.check_outcome(seen);
    end
  end

  // Result side: ready or stalled at random, with stalls in short bursts.
  initial begin
    out_ready <= 1'b0;
    forever begin
      if (!quiet && $urandom_range(0, 99) < stall_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Hard stop in case the unit hangs.
  initial begin
    #200_000;
    $display("tb: failure");
    $finish;
  end

  function automatic logic [15:0] corner(int k);
    case (k)
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h8000;
      3:       return 16'h0080;
      4:       return 16'h00FF;
      default: return 16'h7F01;
    endcase
  endfunction

  function automatic int idle_share();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 20;
      default: return 50;
    endcase
  endfunction

  function automatic logic [15:0] random_operand();
    if ($urandom_range(0, 3) == 0) return corner($urandom_range(0, 5));
    return 16'($urandom);
  endfunction

  function automatic item_t shaped(logic [2:0] cmd, logic [2:0] mode, logic [15:0] mem,
                                   logic [15:0] acc, logic narrow, logic carry);
    item_t it;
    it.cmd             = cmd;
    it.addressing_mode = mode;
    it.access_address  = 24'($urandom);
    it.mem_in          = mem;
    it.acc_in          = acc;
    it.narrow_mode     = narrow;
    it.carry_in        = carry;
    it.neg_in          = ~carry;
    it.ovf_in          = carry;
    it.dp_low_nonzero  = 1'b1;
    it.page_crossed    = 1'b1;
    return it;
  endfunction

  function automatic item_t random_instruction();
    item_t it;
    it.cmd             = ($urandom_range(0, 15) == 0) ? CMD_NONE : 3'($urandom_range(0, 6));
    it.addressing_mode = 3'($urandom_range(0, 7));
    it.access_address  = 24'($urandom);
    it.mem_in          = random_operand();
    it.acc_in          = random_operand();
    it.narrow_mode     = 1'($urandom);
    it.carry_in        = 1'($urandom);
    it.neg_in          = 1'($urandom);
    it.ovf_in          = 1'($urandom);
    it.dp_low_nonzero  = 1'($urandom);
    it.page_crossed    = 1'($urandom);
    return it;
  endfunction

  // Holds the input channel idle for a number of cycles.
  task automatic rest_input(int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Offers one instruction and returns at the edge of its transfer.
  task automatic send_instruction(item_t it);
    in_valid <= 1'b1;
    stim     <= it;
    do @(posedge clk); while (!in_ready);
    if (!quiet && $urandom_range(0, 99) < gap_pct) rest_input($urandom_range(1, 3));
  endtask

  // Stops offering until every outstanding result has come back.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  initial begin
    item_t it;
    tracker   = new();
    gap_pct   = 30;
    stall_pct = 30;
    quiet     = 1'b0;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    stim     <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Every command in both widths, with corner operands and a spread of modes.
    for (int k = 0; k < 16; k++) begin
      it.cmd             = 3'(k >> 1);
      it.addressing_mode = 3'((k * 3) % 8);
      it.access_address  = ((k & 1) != 0) ? 24'hFFFFFF : 24'h000000;
      it.mem_in          = corner(k % 6);
      it.acc_in          = corner((k + 3) % 6);
      it.narrow_mode     = (k & 1) != 0;
      it.carry_in        = (k & 2) != 0;
      it.neg_in          = (k & 4) != 0;
      it.ovf_in          = (k & 2) == 0;
      it.dp_low_nonzero  = 1'b1;
      it.page_crossed    = 1'b1;
      send_instruction(it);
    end

    // Bit test: immediate keeps N and V, the other modes take them from memory.
    send_instruction(shaped(CMD_BIT, MODE_IMM, 16'hC000, 16'h4000, 1'b0, 1'b0));
    send_instruction(shaped(CMD_BIT, MODE_ABSX, 16'h4000, 16'h0000, 1'b0, 1'b1));
    send_instruction(shaped(CMD_BIT, MODE_DPX, 16'h00C0, 16'h0040, 1'b1, 1'b0));
    // Set and reset bits: the direct page penalty applies in direct page mode only.
    send_instruction(shaped(CMD_TSB, MODE_DP, 16'h0F0F, 16'hF0F0, 1'b0, 1'b0));
    send_instruction(shaped(CMD_TRB, MODE_DPX, 16'h0FFF, 16'h00FF, 1'b0, 1'b1));
    // Set bits in accumulator mode still uses memory and writes back.
    send_instruction(shaped(CMD_TSB, MODE_ACC, 16'h1200, 16'h3401, 1'b1, 1'b0));
    // A shift in immediate mode is a memory shift.
    send_instruction(shaped(CMD_ASL, MODE_IMM, 16'h8001, 16'h5555, 1'b0, 1'b1));
    // Rotate right in narrow mode: N follows the old carry, high byte kept.
    send_instruction(shaped(CMD_ROR, MODE_ACC, 16'h0000, 16'hAB01, 1'b1, 1'b1));
    send_instruction(shaped(CMD_LSR, MODE_ABS, 16'h0001, 16'hFFFF, 1'b0, 1'b0));
    send_instruction(shaped(CMD_ROL, MODE_ACC, 16'h0000, 16'h8000, 1'b0, 1'b0));
    send_instruction(shaped(CMD_ROR, MODE_SPARE, 16'h00FE, 16'h0000, 1'b1, 1'b0));
    send_instruction(shaped(CMD_ASL, MODE_OTHER, 16'h4001, 16'h0000, 1'b0, 1'b0));

    // Let everything come back before the random part starts.
    wait_for_drain();

    // Random instructions, changing the idling mix now and then; the tail runs flat out.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 50 == 0) begin
        gap_pct   = idle_share();
        stall_pct = idle_share();
      end
      if (i == RANDOM_ITEMS / 2) wait_for_drain();
      if (i == RANDOM_ITEMS - QUIET_TAIL) quiet = 1'b1;
      send_instruction(random_instruction());
    end

    wait_for_drain();
    repeat (8) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
